// File: sv/actsel_pkg.sv
// Shared constants, types and controller state encoding for activity selection.
package actsel_pkg;

  localparam int MAX_ACTS  = 32;
  localparam int TIME_BITS = 32;
  localparam int ID_W      = 6;
  localparam int IDX_W     = (MAX_ACTS > 1) ? $clog2(MAX_ACTS) : 1;
  localparam int CNT_W     = $clog2(MAX_ACTS + 1);
  localparam int ENTRY_W   = 2 * TIME_BITS;

  typedef enum logic [2:0] {
    ST_LOAD,   // taking requests into the store
    ST_RD,     // read store entry for the scan
    ST_CMP,    // compare entry against the current best
    ST_ROUND,  // end of a scan pass: commit pick or finish
    ST_PRD,    // read pick list
    ST_SRD,    // read store entry of the pick
    ST_OUT     // result on the output channel
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic cmp;
    logic round;
    logic prd;
    logic srd;
    logic emit_next;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic best_valid;
    logic emit_last;
  } sts_t;

endpackage

// File: sv/actsel_ctrl.sv
// Controller state machine: sequences load, selection passes and result output.
module actsel_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_item,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  actsel_pkg::sts_t    sts,
  output actsel_pkg::cmd_t    cmd
);

  actsel_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= actsel_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      actsel_pkg::ST_LOAD: begin
        if (in_valid && in_last_item) state_nxt = actsel_pkg::ST_RD;
      end
      actsel_pkg::ST_RD: begin
        state_nxt = actsel_pkg::ST_CMP;
      end
      actsel_pkg::ST_CMP: begin
        state_nxt = sts.scan_last ? actsel_pkg::ST_ROUND : actsel_pkg::ST_RD;
      end
      actsel_pkg::ST_ROUND: begin
        state_nxt = sts.best_valid ? actsel_pkg::ST_RD : actsel_pkg::ST_PRD;
      end
      actsel_pkg::ST_PRD: begin
        state_nxt = actsel_pkg::ST_SRD;
      end
      actsel_pkg::ST_SRD: begin
        state_nxt = actsel_pkg::ST_OUT;
      end
      actsel_pkg::ST_OUT: begin
        if (!out_stall) state_nxt = sts.emit_last ? actsel_pkg::ST_LOAD : actsel_pkg::ST_PRD;
      end
      default: begin
        state_nxt = actsel_pkg::ST_LOAD;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      actsel_pkg::ST_LOAD: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      actsel_pkg::ST_RD:    cmd.rd    = 1'b1;
      actsel_pkg::ST_CMP:   cmd.cmp   = 1'b1;
      actsel_pkg::ST_ROUND: cmd.round = 1'b1;
      actsel_pkg::ST_PRD:   cmd.prd   = 1'b1;
      actsel_pkg::ST_SRD:   cmd.srd   = 1'b1;
      actsel_pkg::ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_next = !sts.emit_last;
          cmd.clear     = sts.emit_last;
        end
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: sv/actsel_dp.sv
// Datapath: activity store, min-key search unit, pick list and result fields.
module actsel_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  actsel_pkg::cmd_t                  cmd,
  output actsel_pkg::sts_t                  sts,
  input  logic [actsel_pkg::TIME_BITS-1:0]  in_start_time,
  input  logic [actsel_pkg::TIME_BITS-1:0]  in_finish_time,
  input  logic                              in_last_item,
  output logic [actsel_pkg::ID_W-1:0]       out_activity_id,
  output logic [actsel_pkg::TIME_BITS-1:0]  out_sel_start,
  output logic [actsel_pkg::TIME_BITS-1:0]  out_sel_finish,
  output logic [actsel_pkg::ID_W-1:0]       out_selected_total,
  output logic                              out_end_of_run,
  output logic                              out_overflowed
);

  localparam int T  = actsel_pkg::TIME_BITS;
  localparam int IW = actsel_pkg::IDX_W;
  localparam int CW = actsel_pkg::CNT_W;

  logic [actsel_pkg::ENTRY_W-1:0] store_mem [actsel_pkg::MAX_ACTS];
  logic [IW-1:0]                  pick_mem  [actsel_pkg::MAX_ACTS];

  logic [actsel_pkg::ENTRY_W-1:0] rdata_r;
  logic [IW-1:0]                  pick_q_r;

  logic [CW-1:0] count_r,      count_nxt;
  logic          dropped_r,    dropped_nxt;
  logic [IW-1:0] scan_idx_r,   scan_idx_nxt;
  logic          best_valid_r, best_valid_nxt;
  logic [T-1:0]  best_f_r,     best_f_nxt;
  logic [IW-1:0] best_idx_r,   best_idx_nxt;
  logic          have_last_r,  have_last_nxt;
  logic [T-1:0]  last_f_r,     last_f_nxt;
  logic [IW-1:0] last_idx_r,   last_idx_nxt;
  logic [CW-1:0] total_r,      total_nxt;
  logic [IW-1:0] emit_idx_r,   emit_idx_nxt;

  logic          store_full;
  logic [T-1:0]  cand_s, cand_f;
  logic          after_last, fits, take;

  assign store_full = (count_r >= CW'(actsel_pkg::MAX_ACTS));
  assign cand_s     = rdata_r[2*T-1:T];
  assign cand_f     = rdata_r[T-1:0];

  // key order is (finish, arrival); candidate must follow the last pick
  assign after_last = !have_last_r || (cand_f > last_f_r) ||
                      ((cand_f == last_f_r) && (scan_idx_r > last_idx_r));
  assign fits       = !have_last_r || (cand_s >= last_f_r);
  // scan runs in arrival order, so an equal finish never beats the best
  assign take       = after_last && fits && (!best_valid_r || (cand_f < best_f_r));

  always_comb begin
    count_nxt      = count_r;
    dropped_nxt    = dropped_r;
    scan_idx_nxt   = scan_idx_r;
    best_valid_nxt = best_valid_r;
    best_f_nxt     = best_f_r;
    best_idx_nxt   = best_idx_r;
    have_last_nxt  = have_last_r;
    last_f_nxt     = last_f_r;
    last_idx_nxt   = last_idx_r;
    total_nxt      = total_r;
    emit_idx_nxt   = emit_idx_r;

    if (cmd.load) begin
      if (!store_full) count_nxt = count_r + CW'(1);
      else             dropped_nxt = 1'b1;
      if (in_last_item) begin
        have_last_nxt  = 1'b0;
        best_valid_nxt = 1'b0;
        scan_idx_nxt   = '0;
        total_nxt      = '0;
      end
    end

    if (cmd.cmp) begin
      if (take) begin
        best_valid_nxt = 1'b1;
        best_f_nxt     = cand_f;
        best_idx_nxt   = scan_idx_r;
      end
      scan_idx_nxt = scan_idx_r + IW'(1);
    end

    if (cmd.round) begin
      if (best_valid_r) begin
        have_last_nxt  = 1'b1;
        last_f_nxt     = best_f_r;
        last_idx_nxt   = best_idx_r;
        best_valid_nxt = 1'b0;
        total_nxt      = total_r + CW'(1);
        scan_idx_nxt   = '0;
      end else begin
        emit_idx_nxt = '0;
      end
    end

    if (cmd.emit_next) emit_idx_nxt = emit_idx_r + IW'(1);

    if (cmd.clear) begin
      count_nxt   = '0;
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      dropped_r    <= 1'b0;
      scan_idx_r   <= '0;
      best_valid_r <= 1'b0;
      have_last_r  <= 1'b0;
      total_r      <= '0;
      emit_idx_r   <= '0;
    end else begin
      count_r      <= count_nxt;
      dropped_r    <= dropped_nxt;
      scan_idx_r   <= scan_idx_nxt;
      best_valid_r <= best_valid_nxt;
      have_last_r  <= have_last_nxt;
      total_r      <= total_nxt;
      emit_idx_r   <= emit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_f_r   <= best_f_nxt;
    best_idx_r <= best_idx_nxt;
    last_f_r   <= last_f_nxt;
    last_idx_r <= last_idx_nxt;
  end

  // activity store: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      store_mem[count_r[IW-1:0]] <= {in_start_time, in_finish_time};
    end
    if (cmd.rd) begin
      rdata_r <= store_mem[scan_idx_r];
    end else if (cmd.srd) begin
      rdata_r <= store_mem[pick_q_r];
    end
  end

  // pick list, in selection order
  always_ff @(posedge clk) begin
    if (cmd.round && best_valid_r) begin
      pick_mem[total_r[IW-1:0]] <= best_idx_r;
    end
    if (cmd.prd) begin
      pick_q_r <= pick_mem[emit_idx_r];
    end
  end

  assign sts.scan_last  = ((CW'(scan_idx_r) + CW'(1)) == count_r);
  assign sts.best_valid = best_valid_r;
  assign sts.emit_last  = ((CW'(emit_idx_r) + CW'(1)) == total_r);

  assign out_activity_id    = actsel_pkg::ID_W'(pick_q_r) + actsel_pkg::ID_W'(1);
  assign out_sel_start      = cand_s;
  assign out_sel_finish     = cand_f;
  assign out_selected_total = actsel_pkg::ID_W'(total_r);
  assign out_end_of_run     = sts.emit_last;
  assign out_overflowed     = dropped_r;

endmodule

// File: sv/activity_selection.sv
// Top level of the greedy earliest-finish activity selector.
//
// Input channel (in_*): one activity per request, [start, finish). Requests
// are taken at one per cycle while the block is loading; each stored one is
// numbered by arrival from 1. Past capacity, requests are dropped and the
// overflow flag raised. A request with in_last_item set ends the set.
// After the last request the input is stalled while selection runs:
//   each pass reads the n stored activities, a store read then a compare
//   for each, then commits the pick, and there are (selected + 1) passes;
//   each pick is a fresh minimum search, one store read at a time.
// Results (out_*) then leave in sorted order, one request each, each after
// a pick-list read, a store read and a show step, so never back to back.
// A stalled result holds its fields until taken. After the result flagged
// end_of_run is taken the set is cleared and loading resumes.
// Reset (synchronous, rst_n low) empties the store and returns to loading;
// no clearing pass is needed.
module activity_selection (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [actsel_pkg::TIME_BITS-1:0]  in_start_time,
  input  logic [actsel_pkg::TIME_BITS-1:0]  in_finish_time,
  input  logic                              in_last_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [actsel_pkg::ID_W-1:0]       out_activity_id,
  output logic [actsel_pkg::TIME_BITS-1:0]  out_sel_start,
  output logic [actsel_pkg::TIME_BITS-1:0]  out_sel_finish,
  output logic [actsel_pkg::ID_W-1:0]       out_selected_total,
  output logic                              out_end_of_run,
  output logic                              out_overflowed
);

  actsel_pkg::cmd_t cmd;
  actsel_pkg::sts_t sts;

  actsel_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  actsel_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_start_time      (in_start_time),
    .in_finish_time     (in_finish_time),
    .in_last_item       (in_last_item),
    .out_activity_id    (out_activity_id),
    .out_sel_start      (out_sel_start),
    .out_sel_finish     (out_sel_finish),
    .out_selected_total (out_selected_total),
    .out_end_of_run     (out_end_of_run),
    .out_overflowed     (out_overflowed)
  );

endmodule

// File: sv/actsel_checker.sv
// Port-level checks for activity_selection, bound to the top level.
module actsel_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [actsel_pkg::ID_W-1:0]       out_activity_id,
  input logic [actsel_pkg::TIME_BITS-1:0]  out_sel_start,
  input logic [actsel_pkg::TIME_BITS-1:0]  out_sel_finish,
  input logic [actsel_pkg::ID_W-1:0]       out_selected_total
);

  // a held result keeps its fields
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sel_start) &&
      $stable(out_sel_finish) && $stable(out_activity_id))
    else $error("stalled result changed");

  // no loading while results are being delivered
  a_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during output");

  // ids and totals count from one
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_activity_id != '0) && (out_selected_total != '0))
    else $error("zero id or total");

  // each result needs fresh store reads, so a taken result is not followed at once
  a_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall |=> !out_valid)
    else $error("results back to back");

endmodule

bind activity_selection actsel_checker u_actsel_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_activity_id    (out_activity_id),
  .out_sel_start      (out_sel_start),
  .out_sel_finish     (out_sel_finish),
  .out_selected_total (out_selected_total)
);

// File: bench/tb_activity_selection.sv
// Self-checking bench for the activity_selection block, with its own greedy predictor.
module tb_activity_selection;

  localparam int          PERIOD       = 8;
  localparam int          RESET_CYCLES = 9;
  localparam int          IDLE_PCT     = 36;
  localparam int          RANDOM_ITEMS = 335;
  // Worst set: 32 stored, 33 passes over the store, then 32 results.
  localparam int          DRAIN_CYCLES = 2400;
  localparam int unsigned LIMIT_CYCLES = 2_000_000;

  typedef logic [actsel_pkg::TIME_BITS-1:0] stamp_t;

  // One selected activity as it should leave the block.
  typedef struct packed {
    logic [actsel_pkg::ID_W-1:0] id;
    stamp_t                      start_t;
    stamp_t                      finish_t;
    logic [actsel_pkg::ID_W-1:0] total;
    logic                        end_run;
    logic                        overflow;
  } selection_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  stamp_t                      in_start_time;
  stamp_t                      in_finish_time;
  logic                        in_last_item;
  logic                        out_valid;
  logic                        out_stall;
  logic [actsel_pkg::ID_W-1:0] out_activity_id;
  stamp_t                      out_sel_start;
  stamp_t                      out_sel_finish;
  logic [actsel_pkg::ID_W-1:0] out_selected_total;
  logic                        out_end_of_run;
  logic                        out_overflowed;

  // Predictor state: the activities of the set being loaded.
  stamp_t                 held_start [actsel_pkg::MAX_ACTS];
  stamp_t                 held_finish[actsel_pkg::MAX_ACTS];
  int                     held_count;
  bit                     held_dropped;

  selection_t             awaited_q[$];
  int                     mismatch_count;
  // When set, neither side idles nor stalls.
  bit                     steady;

  always #(PERIOD / 2) clk = ~clk;

  activity_selection u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_time      (in_start_time),
    .in_finish_time     (in_finish_time),
    .in_last_item       (in_last_item),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_activity_id    (out_activity_id),
    .out_sel_start      (out_sel_start),
    .out_sel_finish     (out_sel_finish),
    .out_selected_total (out_selected_total),
    .out_end_of_run     (out_end_of_run),
    .out_overflowed     (out_overflowed)
  );

  // ---------------------------------------------------------------------
  // Mismatch reporting: one line per fault, and a running count.
  // ---------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("MISMATCH %s: got %0h, expected %0h (t=%0t)", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------
  // Greedy earliest-finish predictor. Each accepted request is stored (or
  // dropped once the store is full); a request flagged last sorts the set
  // stably by finish, scans from a last finish of 0 and queues one
  // selection per chosen activity. A dropped last request still triggers.
  // ---------------------------------------------------------------------
  task automatic predict_selection(input stamp_t st, input stamp_t fn, input logic last);
    int         order [actsel_pkg::MAX_ACTS];
    int         picked[actsel_pkg::MAX_ACTS];
    int         i;
    int         j;
    int         n_sel;
    stamp_t     reach;
    selection_t sel;
    if (held_count < actsel_pkg::MAX_ACTS) begin
      held_start[held_count]  = st;
      held_finish[held_count] = fn;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;

    // stable insertion sort: strictly greater finishes move up only
    for (i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && held_finish[order[j-1]] > held_finish[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end

    // half-open intervals: touching counts as compatible
    reach = '0;
    n_sel = 0;
    for (i = 0; i < held_count; i++) begin
      if (held_start[order[i]] >= reach) begin
        picked[n_sel] = order[i];
        n_sel++;
        reach = held_finish[order[i]];
      end
    end

    for (i = 0; i < n_sel; i++) begin
      sel.id       = actsel_pkg::ID_W'(picked[i] + 1);
      sel.start_t  = held_start[picked[i]];
      sel.finish_t = held_finish[picked[i]];
      sel.total    = actsel_pkg::ID_W'(n_sel);
      sel.end_run  = (i == n_sel - 1);
      sel.overflow = held_dropped;
      awaited_q.push_back(sel);
    end
    held_count   = 0;
    held_dropped = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Input side. Payload moves at the falling edge; acceptance is seen at
  // the rising edge. Valid is left high after a request so that the next
  // call either idles it or presents the next request, never both in one
  // step. While idle the payload is scrambled to catch stray sampling.
  // ---------------------------------------------------------------------
  task automatic send_activity(input stamp_t st, input stamp_t fn, input logic last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      in_valid       <= 1'b0;
      in_start_time  <= $urandom;
      in_finish_time <= $urandom;
      in_last_item   <= 1'($urandom_range(1));
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_start_time  <= st;
    in_finish_time <= fn;
    in_last_item   <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_selection(st, fn, last);
  endtask

  // Result side: random stalls, changed at the falling edge.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  // Every taken result is matched against the oldest awaited selection.
  always @(posedge clk) begin
    selection_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_q.size() == 0) begin
        report_mismatch("result with nothing awaited", out_activity_id, '0);
      end else begin
        want = awaited_q.pop_front();
        if (out_activity_id !== want.id)
          report_mismatch("activity_id", out_activity_id, want.id);
        if (out_sel_start !== want.start_t)
          report_mismatch("sel_start", out_sel_start, want.start_t);
        if (out_sel_finish !== want.finish_t)
          report_mismatch("sel_finish", out_sel_finish, want.finish_t);
        if (out_selected_total !== want.total)
          report_mismatch("selected_total", out_selected_total, want.total);
        if (out_end_of_run !== want.end_run)
          report_mismatch("end_of_run", out_end_of_run, want.end_run);
        if (out_overflowed !== want.overflow)
          report_mismatch("overflowed", out_overflowed, want.overflow);
      end
    end
  end

  // Time value for one of three shapes: tight (many overlaps and ties),
  // clustered round a random base (upper bits busy), or anything at all.
  function automatic stamp_t pick_time(input int shape, input stamp_t base);
    case (shape)
      0:       pick_time = stamp_t'($urandom_range(63));
      1:       pick_time = base + stamp_t'($urandom_range(255));
      default: pick_time = $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Directed: extreme times, single-activity sets, finish before start.
  // ---------------------------------------------------------------------
  task automatic test_extremes();
    send_activity('0, '0, 1'b1);                 // empty span at zero
    send_activity('1, '1, 1'b1);                 // empty span at the top
    send_activity('1, '0, 1'b1);                 // finish before start
    // equal finishes at the top: both kept, arrival order
    send_activity('0, '1, 1'b0);
    send_activity('1, '1, 1'b1);
    // backwards spans mixed with normal ones
    send_activity(32'd20, 32'd3, 1'b0);
    send_activity(32'd0, 32'd5, 1'b0);
    send_activity(32'd4, 32'd9, 1'b0);
    send_activity(32'hAAAA_5555, 32'h5555_AAAA, 1'b1);
  endtask

  // Directed: ties on finish resolve by arrival; touching spans both fit.
  task automatic test_ties();
    send_activity(32'd0, 32'd10, 1'b0);
    send_activity(32'd0, 32'd10, 1'b0);
    send_activity(32'd5, 32'd10, 1'b0);
    send_activity(32'd10, 32'd20, 1'b0);
    send_activity(32'd20, 32'd20, 1'b0);
    send_activity(32'd0, 32'd5, 1'b0);
    send_activity(32'd5, 32'd10, 1'b1);
  endtask

  // Capacity: a last request that lands on a full store is dropped but
  // still closes the set; then a set that spills several requests.
  task automatic test_capacity();
    int i;
    for (i = 0; i < actsel_pkg::MAX_ACTS; i++)
      send_activity(pick_time(0, '0), pick_time(0, '0), 1'b0);
    send_activity(32'd0, 32'd1, 1'b1);
    for (i = 0; i < actsel_pkg::MAX_ACTS + 4; i++)
      send_activity(stamp_t'(i * 3), stamp_t'(i * 3 + 4), i == actsel_pkg::MAX_ACTS + 3);
  endtask

  // Random sets, mostly small, now and then past capacity. The first
  // stretch runs with no idling on either side.
  task automatic test_random_sets();
    int     sent;
    int     set_len;
    int     shape;
    int     k;
    stamp_t base;
    stamp_t t_a;
    stamp_t t_b;
    sent   = 0;
    steady = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 120) steady = 1'b0;
      set_len = ($urandom_range(9) == 0) ? $urandom_range(20, actsel_pkg::MAX_ACTS + 8)
                                         : $urandom_range(1, 12);
      shape   = $urandom_range(2);
      base    = $urandom;
      for (k = 0; k < set_len; k++) begin
        t_a = pick_time(shape, base);
        t_b = pick_time(shape, base);
        // mostly well-formed spans, the odd one backwards
        if ($urandom_range(99) < 85 && t_b < t_a)
          send_activity(t_b, t_a, k == set_len - 1);
        else
          send_activity(t_a, t_b, k == set_len - 1);
      end
      sent += set_len;
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_start_time  = '0;
    in_finish_time = '0;
    in_last_item   = 1'b0;
    out_stall      = 1'b0;
    held_count     = 0;
    held_dropped   = 1'b0;
    mismatch_count = 0;
    steady         = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_ties();
    test_capacity();
    test_random_sets();

    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    // give any stray extra result time to show
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0)
      $display("tb_activity_selection OK");
    else
      $display("tb_activity_selection NOT OK");
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * PERIOD);
    $display("tb_activity_selection NOT OK");
    $finish;
  end

endmodule
